// File: rtl/pswi_pkg.sv
// Shared types, constants and helpers for the windowed-integral PID block.
package pswi_pkg;

  localparam int DATA_W  = 32;
  localparam int ERR_W   = 33;
  localparam int DIFF_W  = 34;
  localparam int CHUNK_W = 26;
  localparam int OPND_W  = CHUNK_W + 1;
  localparam int INNER_W = 2 * CHUNK_W;
  localparam int PROD_W  = DATA_W + OPND_W;
  localparam int ACC_W   = DATA_W + INNER_W;
  localparam int FRAC_W  = 16;
  localparam int WL_W    = 5;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP_ZERO = 3'd4;

  localparam logic [DATA_W-1:0] KP_RESET = 32'h0001_0000;
  localparam logic [WL_W-1:0]   WL_RESET = 5'd10;
  localparam logic [DATA_W-1:0] Q_MAX    = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_MIN    = 32'h8000_0000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    MAC_NONE,
    MAC_LOAD,
    MAC_ADD_HI
  } mac_cmd_t;

  typedef struct packed {
    logic     issue;
    mac_cmd_t cmd;
  } mac_ctl_t;

  // Pick the low (unsigned) or high (signed) chunk of a wide operand.
  function automatic logic [OPND_W-1:0] opnd_chunk(input logic [INNER_W-1:0] x,
                                                   input logic hi);
    logic [OPND_W-1:0] r;
    if (hi) begin
      r = {x[INNER_W-1], x[INNER_W-1:CHUNK_W]};
    end else begin
      r = {1'b0, x[CHUNK_W-1:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/pid_sliding_window_integral.sv
// Top level of the windowed-integral PID controller.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one item: setpoint and measured,
//   both signed Q16.16. Output channel (out_valid/out_ready) returns one item
//   per input: drive (signed Q16.16, clipped to 32 bits) and saturated.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
//   ready; write it only while no item is in flight. Unknown indexes drop.
//   Steps: an accept step, then the window sum walks the error ring RAM at
//   one entry per cycle, then the shared 32x27 multiplier forms two partial
//   products for each of ki*sum, kd*delta and kp*inner, then a hand-off
//   step. With time_step_zero set the item skips the sum and multiply.
//   The block takes no new item until it is through with the last one;
//   the ring walk and the multiplier schedule set the pace. A finished
//   result sits in the output register, and the block goes back to
//   accept the next item while it waits.
//   When the receiver stalls, the next result holds in its done state until
//   the output register frees up.
//   Reset: synchronous, active high; gains go to kp = 1.0, ki = kd = 0,
//   window 10, history empty, previous error zero. No clearing pass.
module pid_sliding_window_integral
  import pswi_pkg::*;
#(
  parameter int HIST_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] setpoint,
  input  logic signed [DATA_W-1:0] measured,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] drive,
  output logic                     saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data
);

  localparam int AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FW    = $clog2(HIST_DEPTH + 1);
  localparam int CW    = (FW > WL_W) ? FW : WL_W;
  localparam int SUM_W = ERR_W + FW;

  // multiply schedule steps
  localparam logic [3:0] STEP_I_LO  = 4'd0;
  localparam logic [3:0] STEP_I_HI  = 4'd1;
  localparam logic [3:0] STEP_D_LO  = 4'd2;
  localparam logic [3:0] STEP_D_HI  = 4'd3;
  localparam logic [3:0] STEP_D_ADD = 4'd4;
  localparam logic [3:0] STEP_D_ACC = 4'd5;
  localparam logic [3:0] STEP_P_LO  = 4'd6;
  localparam logic [3:0] STEP_P_HI  = 4'd7;
  localparam logic [3:0] STEP_P_ADD = 4'd8;
  localparam logic [3:0] STEP_LAST  = 4'd9;

  // configuration registers
  logic signed [DATA_W-1:0] prop_gain;
  logic signed [DATA_W-1:0] integral_gain;
  logic signed [DATA_W-1:0] deriv_gain;
  logic [WL_W-1:0]          window_length;
  logic                     time_step_zero;

  // control and datapath state
  state_t                    state, state_next;
  logic [AW-1:0]             ring_head;
  logic [FW-1:0]             ring_fill;
  logic [FW-1:0]             fill_next;
  logic [FW-1:0]             n_next;
  logic [AW-1:0]             rd_addr;
  logic [FW-1:0]             rd_left;
  logic                      rd_pend;
  logic [3:0]                ustep;
  logic signed [ERR_W-1:0]   error, error_next;
  logic signed [ERR_W-1:0]   prev_error;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SUM_W-1:0]   sum;
  logic signed [DATA_W-1:0]  ssum, ssum_next;
  logic signed [INNER_W-1:0] inner;
  logic signed [DATA_W-1:0]  res_drive;
  logic                      res_sat;

  logic                      in_acc;
  logic                      sum_done;
  logic                      out_load;
  logic                      ram_re;
  logic [ERR_W-1:0]          ram_rdata;
  logic [SUM_W-DATA_W:0]     sum_sel;
  logic                      sum_fits;
  logic [ACC_W-FRAC_W-DATA_W:0] q_hi;
  logic                      q_fits;

  mac_ctl_t                  mac_ctl;
  logic signed [DATA_W-1:0]  mac_gain;
  logic signed [OPND_W-1:0]  mac_opnd;
  logic signed [ACC_W-1:0]   acc;

  logic [CW-1:0]             wl_c, depth_c, fill_c, n_c;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & in_ready;
  assign sum_done  = (rd_left == '0) & ~rd_pend;
  assign out_load  = (state == S_DONE) & (~out_valid | out_ready);

  assign error_next = {setpoint[DATA_W-1], setpoint} - {measured[DATA_W-1], measured};

  // Window length clamps to the depth and to the filled history.
  always_comb begin
    fill_next = (ring_fill < FW'(HIST_DEPTH)) ? ring_fill + 1'b1 : ring_fill;
    wl_c      = CW'(window_length);
    depth_c   = CW'(HIST_DEPTH);
    fill_c    = CW'(fill_next);
    n_c       = wl_c;
    if (n_c > depth_c) begin
      n_c = depth_c;
    end
    if (n_c > fill_c) begin
      n_c = fill_c;
    end
    n_next = FW'(n_c);
  end

  // Clip the window sum to 32 bits for the integral product.
  assign sum_sel  = sum[SUM_W-1:DATA_W-1];
  assign sum_fits = (&sum_sel) | ~(|sum_sel);
  assign ssum_next = sum_fits ? sum[DATA_W-1:0] : (sum[SUM_W-1] ? Q_MIN : Q_MAX);

  // Final product: drive = floor(kp * inner / 2^16), clipped.
  assign q_hi   = acc[ACC_W-1:FRAC_W+DATA_W-1];
  assign q_fits = (&q_hi) | ~(|q_hi);

  pswi_ram #(
    .WIDTH (ERR_W),
    .DEPTH (HIST_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (in_acc),
    .waddr (ring_head),
    .wdata (error_next),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  pswi_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .gain (mac_gain),
    .opnd (mac_opnd),
    .acc  (acc)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = time_step_zero ? S_DONE : S_SUM;
        end
      end
      S_SUM: begin
        if (sum_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (ustep == STEP_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, ring read, multiplier schedule.
  always_comb begin
    in_ready      = (state == S_IDLE);
    ram_re        = (state == S_SUM) & (rd_left != '0);
    mac_ctl.issue = 1'b0;
    mac_ctl.cmd   = MAC_NONE;
    mac_gain      = prop_gain;
    mac_opnd      = opnd_chunk(inner, 1'b0);
    if (state == S_MUL) begin
      case (ustep)
        STEP_I_LO: begin
          mac_ctl.issue = 1'b1;
          mac_gain      = integral_gain;
          mac_opnd      = opnd_chunk({{(INNER_W-DATA_W){ssum[DATA_W-1]}}, ssum}, 1'b0);
        end
        STEP_I_HI: begin
          mac_ctl.issue = 1'b1;
          mac_ctl.cmd   = MAC_LOAD;
          mac_gain      = integral_gain;
          mac_opnd      = opnd_chunk({{(INNER_W-DATA_W){ssum[DATA_W-1]}}, ssum}, 1'b1);
        end
        STEP_D_LO: begin
          mac_ctl.issue = 1'b1;
          mac_ctl.cmd   = MAC_ADD_HI;
          mac_gain      = deriv_gain;
          mac_opnd      = opnd_chunk({{(INNER_W-DIFF_W){diff[DIFF_W-1]}}, diff}, 1'b0);
        end
        STEP_D_HI: begin
          mac_ctl.issue = 1'b1;
          mac_ctl.cmd   = MAC_LOAD;
          mac_gain      = deriv_gain;
          mac_opnd      = opnd_chunk({{(INNER_W-DIFF_W){diff[DIFF_W-1]}}, diff}, 1'b1);
        end
        STEP_D_ADD: mac_ctl.cmd = MAC_ADD_HI;
        STEP_P_LO: begin
          mac_ctl.issue = 1'b1;
          mac_opnd      = opnd_chunk(inner, 1'b0);
        end
        STEP_P_HI: begin
          mac_ctl.issue = 1'b1;
          mac_ctl.cmd   = MAC_LOAD;
          mac_opnd      = opnd_chunk(inner, 1'b1);
        end
        STEP_P_ADD: mac_ctl.cmd = MAC_ADD_HI;
        default: mac_ctl.cmd = MAC_NONE;
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      ring_head      <= '0;
      ring_fill      <= '0;
      prev_error     <= '0;
      rd_left        <= '0;
      rd_pend        <= 1'b0;
      ustep          <= '0;
      prop_gain      <= KP_RESET;
      integral_gain  <= '0;
      deriv_gain     <= '0;
      window_length  <= WL_RESET;
      time_step_zero <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid & cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:      prop_gain      <= cfg_data;
          REG_INTEGRAL_GAIN:  integral_gain  <= cfg_data;
          REG_DERIV_GAIN:     deriv_gain     <= cfg_data;
          REG_WINDOW_LENGTH:  window_length  <= cfg_data[WL_W-1:0];
          REG_TIME_STEP_ZERO: time_step_zero <= cfg_data[0];
          default: ;
        endcase
      end

      // Advance the ring on every accepted item.
      if (in_acc) begin
        ring_head <= (ring_head == AW'(HIST_DEPTH - 1)) ? '0 : ring_head + 1'b1;
        ring_fill <= fill_next;
        rd_left   <= n_next;
        rd_pend   <= 1'b0;
      end else if (state == S_SUM) begin
        rd_pend <= ram_re;
        if (ram_re) begin
          rd_left <= rd_left - 1'b1;
        end
      end

      if (state == S_SUM) begin
        ustep <= '0;
      end else if (state == S_MUL) begin
        ustep <= ustep + 1'b1;
      end

      if ((state == S_MUL) && (ustep == STEP_LAST)) begin
        prev_error <= error;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      error   <= error_next;
      rd_addr <= ring_head;
      sum     <= '0;
      if (time_step_zero) begin
        res_drive <= '0;
        res_sat   <= 1'b0;
      end
    end

    if (state == S_SUM) begin
      diff <= {error[ERR_W-1], error} - {prev_error[ERR_W-1], prev_error};
      if (ram_re) begin
        rd_addr <= (rd_addr == '0) ? AW'(HIST_DEPTH - 1) : rd_addr - 1'b1;
      end
      if (rd_pend) begin
        sum <= sum + {{(SUM_W-ERR_W){ram_rdata[ERR_W-1]}}, ram_rdata};
      end
      if (sum_done) begin
        ssum <= ssum_next;
      end
    end

    if (state == S_MUL) begin
      case (ustep)
        STEP_D_HI: begin
          inner <= {{(INNER_W-ERR_W){error[ERR_W-1]}}, error} + acc[FRAC_W +: INNER_W];
        end
        STEP_D_ACC: inner <= inner + acc[FRAC_W +: INNER_W];
        STEP_LAST: begin
          res_drive <= q_fits ? acc[FRAC_W +: DATA_W] : (acc[ACC_W-1] ? Q_MIN : Q_MAX);
          res_sat   <= ~q_fits;
        end
        default: ;
      endcase
    end

    if (out_load) begin
      drive     <= res_drive;
      saturated <= res_sat;
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= FW'(HIST_DEPTH))
    else $error("ring fill count above depth");

  a_window_in_history: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM) |-> (rd_left <= ring_fill))
    else $error("window walk reaches past filled history");

  a_add_after_load: assert property (@(posedge clk) disable iff (rst)
    (mac_ctl.cmd == MAC_ADD_HI) |-> ($past(mac_ctl.cmd) == MAC_LOAD))
    else $error("high partial product added without low one loaded");

  a_sat_clipped: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (drive == Q_MAX || drive == Q_MIN))
    else $error("saturated flag set on an unclipped drive");
`endif

endmodule

// File: rtl/pswi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pswi_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/pswi_mac.sv
// Shared multiplier with product register and shift-accumulate stage.
module pswi_mac
  import pswi_pkg::*;
(
  input  logic                     clk,
  input  mac_ctl_t                 ctl,
  input  logic signed [DATA_W-1:0] gain,
  input  logic signed [OPND_W-1:0] opnd,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod;
  logic        [ACC_W-1:0]  prod_ext;

  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod <= gain * opnd;
    end
    case (ctl.cmd)
      MAC_LOAD:   acc <= prod_ext;
      MAC_ADD_HI: acc <= acc + {prod_ext[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
      default:    acc <= acc;
    endcase
  end

endmodule

// File: tb/pid_drive_checker.sv
// Checker for the windowed-integral PID block: predicts each drive result and compares it.
module pid_drive_checker
  import pswi_pkg::*;
#(
  parameter int HIST_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic signed [DATA_W-1:0] setpoint,
  input  logic signed [DATA_W-1:0] measured,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] drive,
  input  logic                     saturated,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  output int                       mismatches,
  output int                       waiting,
  output int                       compared
);

  localparam logic signed [63:0] TOP32 = 64'sd2147483647;
  localparam logic signed [63:0] BOT32 = -64'sd2147483648;
  localparam int PRINT_CAP = 40;

  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic                     clip;
  } drive_t;

  drive_t drive_q[$];

  logic signed [DATA_W-1:0] kp, ki, kd;
  logic [WL_W-1:0]          win_len;
  logic                     zero_step;
  logic signed [63:0]       err_hist [HIST_DEPTH];
  int                       hist_fill, hist_head;
  logic signed [63:0]       last_err;

  // floor(g * x / 2^16), held within +-2^62
  function automatic logic signed [63:0] q16_mul(input logic signed [DATA_W-1:0] g,
                                                 input logic signed [63:0] x);
    logic signed [127:0] p;
    logic signed [127:0] lim;
    lim = 128'sd1 <<< 62;
    p = g * x;
    p = p >>> FRAC_W;
    if (p > lim) begin
      p = lim;
    end else if (p < -lim) begin
      p = -lim;
    end
    return p[63:0];
  endfunction

  // {clipped, value} after clamping to the signed 32-bit range
  function automatic logic [DATA_W:0] sat32(input logic signed [63:0] v);
    if (v > TOP32) begin
      return {1'b1, Q_MAX};
    end else if (v < BOT32) begin
      return {1'b1, Q_MIN};
    end
    return {1'b0, v[DATA_W-1:0]};
  endfunction

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  task automatic clear_model();
    kp        = KP_RESET;
    ki        = '0;
    kd        = '0;
    win_len   = WL_RESET;
    zero_step = 1'b0;
    hist_fill = 0;
    hist_head = 0;
    last_err  = '0;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      err_hist[i] = '0;
    end
  endtask

  task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    case (idx)
      REG_PROP_GAIN:      kp = val;
      REG_INTEGRAL_GAIN:  ki = val;
      REG_DERIV_GAIN:     kd = val;
      REG_WINDOW_LENGTH:  win_len = val[WL_W-1:0];
      REG_TIME_STEP_ZERO: zero_step = val[0];
      default: ;
    endcase
  endtask

  task automatic predict_drive(input logic signed [DATA_W-1:0] sp,
                               input logic signed [DATA_W-1:0] ms);
    logic signed [63:0] err, wsum, ssum, i_term, d_term, inner;
    logic [DATA_W:0]    packed_sat;
    int                 n, idx, k;
    drive_t             res;
    err = sp - ms;
    err_hist[hist_head] = err;
    hist_head = (hist_head + 1) % HIST_DEPTH;
    if (hist_fill < HIST_DEPTH) hist_fill++;

    n = win_len;
    if (n > HIST_DEPTH) n = HIST_DEPTH;
    if (n > hist_fill) n = hist_fill;
    idx  = hist_head;
    wsum = '0;
    for (k = 0; k < n; k++) begin
      idx  = (idx + HIST_DEPTH - 1) % HIST_DEPTH;
      wsum = wsum + err_hist[idx];
    end

    if (zero_step) begin
      res.drive = '0;
      res.clip  = 1'b0;
    end else begin
      packed_sat = sat32(wsum);
      ssum       = $signed(packed_sat[DATA_W-1:0]);
      i_term     = (ki == 0) ? 64'sd0 : q16_mul(ki, ssum);
      d_term     = q16_mul(kd, err - last_err);
      inner      = err + i_term + d_term;
      packed_sat = sat32(q16_mul(kp, inner));
      res.drive  = packed_sat[DATA_W-1:0];
      res.clip   = packed_sat[DATA_W];
      last_err   = err;
    end
    drive_q = {drive_q, res};
  endtask

  task automatic check_drive();
    drive_t want;
    if (drive_q.size() == 0) begin
      report("result with no item pending, drive", drive, '0);
      return;
    end
    want = drive_q[0];
    drive_q.delete(0);
    if (drive !== want.drive) report("drive", drive, want.drive);
    if (saturated !== want.clip) report("saturated", {31'b0, saturated}, {31'b0, want.clip});
    compared++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      drive_q.delete();
      mismatches = 0;
      compared   = 0;
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      // Compare before predicting so a stray result never pairs with a fresh item.
      if (out_valid && out_ready) check_drive();
      if (in_valid && in_ready) predict_drive(setpoint, measured);
    end
    waiting = drive_q.size();
  end

endmodule

// File: tb/tb_pid_sliding_window_integral.sv
// Testbench top: drives the windowed-integral PID block, stalls its output and gives the verdict.
module tb_pid_sliding_window_integral;
  import pswi_pkg::*;

  localparam int HIST_DEPTH   = 16;
  localparam int CLK_PERIOD   = 8;
  localparam int RANDOM_ITEMS = 1650;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_CYCLES = 1000000;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid, in_ready;
  logic signed [DATA_W-1:0] setpoint, measured;
  logic                     out_valid, out_ready;
  logic signed [DATA_W-1:0] drive;
  logic                     saturated;
  logic                     cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  int   mismatches, waiting, compared;
  int   items_sent;
  int   settings_used;
  int   burst_left;
  logic gapless;

  pid_sliding_window_integral #(.HIST_DEPTH(HIST_DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .setpoint  (setpoint),
    .measured  (measured),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pid_drive_checker #(.HIST_DEPTH(HIST_DEPTH)) drive_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .setpoint   (setpoint),
    .measured   (measured),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drive      (drive),
    .saturated  (saturated),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .waiting    (waiting),
    .compared   (compared)
  );

  // Free-running clock, low then high.
  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("FAILURE");
    $finish;
  end

  // Receiver: switch among open, light, heavy and beating stall patterns
  // in stretches of random length. Change ready only on the falling edge.
  initial begin
    int       stretch;
    rx_mode_t mode;
    out_ready = 1'b0;
    stretch   = 0;
    mode      = RX_OPEN;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        mode    = rx_mode_t'($urandom_range(0, 3));
        stretch = $urandom_range(10, 200);
      end
      stretch--;
      case (mode)
        RX_OPEN:  out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY: out_ready <= ($urandom_range(0, 7) == 0);
        default:  out_ready <= stretch[2];
      endcase
    end
  end

  // Write one register; call on a falling edge, return on a falling edge
  // with valid already dropped across a rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one item and hold it until accepted; valid stays high on return.
  task automatic send_item(input logic signed [DATA_W-1:0] sp,
                           input logic signed [DATA_W-1:0] ms);
    in_valid <= 1'b1;
    setpoint <= sp;
    measured <= ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop valid and pause the sender; n (n >= 1) sets the pause length.
  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has been taken,
  // then wait on while the block settles back to idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Pace the sender after an item: bursts with random gaps (none in a gapless
  // phase), and now and then a full drain so the block sees an empty pipe mid-phase.
  task automatic pace();
    if ($urandom_range(0, 79) == 0) begin
      settle();
      burst_left = $urandom_range(1, 20);
    end else if (!gapless) begin
      burst_left--;
      if (burst_left <= 0) begin
        if ($urandom_range(0, 7) == 0) pause_sender($urandom_range(5, 40));
        else pause_sender($urandom_range(1, 4));
        burst_left = $urandom_range(1, 20);
      end
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return Q_MAX;
      2:       return Q_MIN;
      3:       return 32'h0001_0000;
      4:       return 32'hFFFF_0000;
      5, 6:    return $urandom_range(0, 32'h0004_0000);
      7:       return -$urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // Window length in the low bits; junk above them now and then.
  function automatic logic [DATA_W-1:0] pick_window();
    logic [DATA_W-1:0] w;
    case ($urandom_range(0, 5))
      0:       w = 0;
      1:       w = HIST_DEPTH;
      2:       w = $urandom_range(HIST_DEPTH + 1, (1 << WL_W) - 1);
      3:       w = 1;
      default: w = $urandom_range(0, HIST_DEPTH);
    endcase
    if ($urandom_range(0, 3) == 0) w = ($urandom & ~((1 << WL_W) - 1)) | w;
    return w;
  endfunction

  // Tracking-style pairs near each other, moderate independent pairs, noise and extremes.
  task automatic make_pair(output logic signed [DATA_W-1:0] sp,
                           output logic signed [DATA_W-1:0] ms);
    logic signed [DATA_W-1:0] corner [5];
    corner = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};
    case ($urandom_range(0, 9))
      0, 1: begin
        sp = $urandom;
        ms = $urandom;
      end
      2: begin
        sp = corner[$urandom_range(0, 4)];
        ms = corner[$urandom_range(0, 4)];
      end
      3, 4, 5: begin
        sp = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        ms = sp + ($signed($urandom_range(0, 32'h0001_0000)) - 32'sh0000_8000);
      end
      default: begin
        sp = $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
        ms = $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
      end
    endcase
  endtask

  initial begin
    logic signed [DATA_W-1:0] sp, ms;
    int                       directed_end;
    int                       phase_items;
    rst        = 1'b1;
    in_valid   = 1'b0;
    setpoint   = '0;
    measured   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_PROP_GAIN;
    cfg_data   = '0;
    items_sent = 0;
    burst_left = 1;
    gapless    = 1'b1;
    settings_used = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: unit kp, no integral or derivative, window of ten
    // that is longer than the history at first.
    send_item(32'sh0, 32'sh0);
    send_item(Q_MAX, Q_MIN);
    send_item(Q_MIN, Q_MAX);
    send_item(32'sh0001_8000, 32'sh0000_4000);
    send_item(-32'sd1, 32'sh0);
    settle();

    // Every gain at its positive extreme, window exactly the ring depth.
    write_reg(REG_PROP_GAIN, Q_MAX);
    write_reg(REG_INTEGRAL_GAIN, Q_MAX);
    write_reg(REG_DERIV_GAIN, Q_MAX);
    write_reg(REG_WINDOW_LENGTH, HIST_DEPTH);
    settings_used++;
    send_item(Q_MAX, Q_MIN);
    send_item(Q_MIN, Q_MAX);
    send_item(Q_MAX, Q_MIN);
    settle();

    // Negative extremes, window beyond the ring depth (clamped).
    write_reg(REG_PROP_GAIN, Q_MIN);
    write_reg(REG_INTEGRAL_GAIN, Q_MIN);
    write_reg(REG_DERIV_GAIN, Q_MIN);
    write_reg(REG_WINDOW_LENGTH, (1 << WL_W) - 1);
    settings_used++;
    send_item(Q_MIN, Q_MAX);
    send_item(Q_MAX, Q_MIN);
    send_item(32'sh0000_1234, -32'sh0000_5678);
    settle();

    // Empty window: integral term drops out.
    write_reg(REG_PROP_GAIN, KP_RESET);
    write_reg(REG_INTEGRAL_GAIN, 32'h0000_8000);
    write_reg(REG_DERIV_GAIN, 32'h0001_0000);
    write_reg(REG_WINDOW_LENGTH, 0);
    settings_used++;
    send_item(32'sh0002_0000, 32'sh0001_0000);
    send_item(-32'sh0002_0000, 32'sh0001_0000);
    settle();

    // Zero time step: output forced to zero, ring still fills,
    // previous error held for the next live step.
    write_reg(REG_WINDOW_LENGTH, 5);
    write_reg(REG_TIME_STEP_ZERO, 1);
    settings_used++;
    send_item(32'sh0003_0000, 32'sh0);
    send_item(Q_MAX, Q_MIN);
    send_item(-32'sh0001_0000, 32'sh0);
    settle();

    // Back to live steps; unused indexes must leave everything alone.
    write_reg(REG_TIME_STEP_ZERO, 0);
    for (int r = REG_TIME_STEP_ZERO + 1; r < (1 << CFG_IDX_W); r++) begin
      write_reg(CFG_IDX_W'(r), $urandom);
    end
    settings_used++;
    send_item(32'sh0001_0000, 32'sh0);
    send_item(32'sh0001_0000, 32'sh0000_8000);
    send_item(32'sh0, 32'sh0);
    directed_end = items_sent;

    // Random phases: new register settings between drains, then a run
    // of items under random sender pacing.
    while (items_sent < directed_end + RANDOM_ITEMS) begin
      settle();
      if ($urandom_range(0, 1)) write_reg(REG_PROP_GAIN, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_INTEGRAL_GAIN, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_DERIV_GAIN, pick_gain());
      if ($urandom_range(0, 1)) write_reg(REG_WINDOW_LENGTH, pick_window());
      write_reg(REG_TIME_STEP_ZERO,
                ($urandom & ~32'h1) | DATA_W'($urandom_range(0, 5) == 0));
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_TIME_STEP_ZERO + 1, (1 << CFG_IDX_W) - 1)),
                  $urandom);
      end
      settings_used++;
      gapless     = ($urandom_range(0, 3) == 0);
      burst_left  = $urandom_range(1, 20);
      phase_items = $urandom_range(8, 60);
      repeat (phase_items) begin
        make_pair(sp, ms);
        send_item(sp, ms);
        pace();
      end
    end

    // Drain, then watch a while longer for stray results.
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d items under %0d register settings, %0d results compared.",
             items_sent, settings_used, compared);
    $display("Covered gain extremes, windows from empty past the ring depth, zero time step.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pswi_pkg.sv
rtl/pswi_ram.sv
rtl/pswi_mac.sv
rtl/pid_sliding_window_integral.sv
tb/pid_drive_checker.sv
tb/tb_pid_sliding_window_integral.sv
